@@ hdl/dda_line_rasterizer_defines.svh @@
// Assertion macros used by the checker file of the line rasterizer.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// Implication in the same cycle, ignored while reset is asserted.
`define DLR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dda_line_rasterizer: same-cycle check failed");

// Implication into the next cycle, ignored while reset is asserted.
`define DLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dda_line_rasterizer: next-cycle check failed");

// Implication into the next cycle that also holds across reset.
`define DLR_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dda_line_rasterizer: post-reset check failed");

`endif

@@ hdl/dlr_pkg.sv @@
// Shared codes and types of the line rasterizer.
`default_nettype none
package dlr_pkg;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        BK_RUN,
        BK_DIV
    } t_bk_state;

endpackage
`default_nettype wire

@@ hdl/dda_line_rasterizer.sv @@
// Top level of the DDA line rasterizer: front end, command queue, divider and back end.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    i_action, i_start_x, i_start_y, i_end_x, i_end_y
//   output    out        o_valid / i_stall    o_pixel_valid, o_pixel_x, o_pixel_y, o_last
//
// A step item is popped from the head of the queue into the registered pixel output, so
// steps run at one per cycle while no division runs and the output is not stalled.
// A start item occupies the back end until the bit-serial divider is done, unless the
// line has zero length. The four-entry queue keeps accepting items while the divider
// runs. Reset is synchronous and leaves no line active with an empty queue.
// A stall on the output holds the pixel register and backs up through the queue.
`default_nettype none
module dda_line_rasterizer #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_pixel_valid,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_last
);
    import dlr_pkg::*;

    localparam int CMD_W = 5 * COORD_BITS + 3;

    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;
    logic [CMD_W-1:0]      cmd_in;
    logic [CMD_W-1:0]      cmd_out;
    logic                  div_start;
    logic                  div_done;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] side;
    logic [FRAC_BITS:0]    qx;
    logic [FRAC_BITS:0]    qy;

    dlr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_start_x(i_start_x),
        .i_start_y(i_start_y),
        .i_end_x  (i_end_x),
        .i_end_y  (i_end_y),
        .i_full   (full),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    dlr_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (cmd_in),
        .i_pop  (pop),
        .o_data (cmd_out),
        .o_full (full),
        .o_empty(empty)
    );

    dlr_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_adx  (adx),
        .i_ady  (ady),
        .i_side (side),
        .o_done (div_done),
        .o_qx   (qx),
        .o_qy   (qy)
    );

    dlr_back #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_out),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_div_start  (div_start),
        .o_adx        (adx),
        .o_ady        (ady),
        .o_side       (side),
        .i_div_done   (div_done),
        .i_qx         (qx),
        .i_qy         (qy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_valid(o_pixel_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

@@ hdl/dlr_front.sv @@
// Front end: accepts items, classifies them and computes the line deltas.
`default_nettype none
module dlr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic                         i_full,
    output logic                         o_push,
    output logic [5*COORD_BITS+2:0]      o_cmd
);
    import dlr_pkg::*;

    localparam int C = COORD_BITS;

    logic [C:0]   dx;
    logic [C:0]   dy;
    logic [C-1:0] adx;
    logic [C-1:0] ady;
    logic [C-1:0] side;

    always_comb begin
        dx   = {i_end_x[C-1], i_end_x} - {i_start_x[C-1], i_start_x};
        dy   = {i_end_y[C-1], i_end_y} - {i_start_y[C-1], i_start_y};
        adx  = dx[C] ? C'(-dx) : dx[C-1:0];
        ady  = dy[C] ? C'(-dy) : dy[C-1:0];
        side = (adx >= ady) ? adx : ady;
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign o_cmd   = (i_action == ACT_START)
                   ? {ACT_START, i_start_x, i_start_y, dx[C], dy[C], adx, ady, side}
                   : {ACT_STEP, {(5*C+2){1'b0}}};

endmodule
`default_nettype wire

@@ hdl/dlr_fifo.sv @@
// Short command queue between the front end and the back end.
`default_nettype none
module dlr_fifo #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/dlr_div.sv @@
// Two-lane restoring divider for the rounded per-step increments.
`default_nettype none
module dlr_div #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_adx,
    input  logic [COORD_BITS-1:0] i_ady,
    input  logic [COORD_BITS-1:0] i_side,
    output logic                  o_done,
    output logic [FRAC_BITS:0]    o_qx,
    output logic [FRAC_BITS:0]    o_qy
);
    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NW = C + F + 1;
    localparam int QW = F + 1;
    localparam int CW = $clog2(F + 2);

    logic [NW-1:0] num_x;
    logic [NW-1:0] num_y;
    logic [C:0]    sh_x;
    logic [C:0]    sh_y;
    logic          ge_x;
    logic          ge_y;

    logic [C-1:0]  r_side;
    logic [C-1:0]  r_rem_x;
    logic [C-1:0]  r_rem_y;
    logic [QW-1:0] r_lo_x;
    logic [QW-1:0] r_lo_y;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    // Adding half the divisor first turns the floor division into round to nearest.
    always_comb begin
        num_x = (NW'(i_adx) << F) + NW'(i_side >> 1);
        num_y = (NW'(i_ady) << F) + NW'(i_side >> 1);
        sh_x  = {r_rem_x, r_lo_x[QW-1]};
        sh_y  = {r_rem_y, r_lo_y[QW-1]};
        ge_x  = (sh_x >= {1'b0, r_side});
        ge_y  = (sh_y >= {1'b0, r_side});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_side  <= i_side;
            r_rem_x <= num_x[NW-1:QW];
            r_rem_y <= num_y[NW-1:QW];
            r_lo_x  <= num_x[QW-1:0];
            r_lo_y  <= num_y[QW-1:0];
        end else if (r_busy) begin
            r_rem_x <= ge_x ? C'(sh_x - {1'b0, r_side}) : C'(sh_x);
            r_rem_y <= ge_y ? C'(sh_y - {1'b0, r_side}) : C'(sh_y);
            r_lo_x  <= {r_lo_x[QW-2:0], ge_x};
            r_lo_y  <= {r_lo_y[QW-2:0], ge_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(F)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_qx   = r_lo_x;
    assign o_qy   = r_lo_y;

endmodule
`default_nettype wire

@@ hdl/dlr_back.sv @@
// Back end: runs queued commands, holds the line state and drives the pixel output.
`default_nettype none
module dlr_back #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [5*COORD_BITS+2:0]      i_cmd,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_div_start,
    output logic [COORD_BITS-1:0]        o_adx,
    output logic [COORD_BITS-1:0]        o_ady,
    output logic [COORD_BITS-1:0]        o_side,
    input  logic                         i_div_done,
    input  logic [FRAC_BITS:0]           i_qx,
    input  logic [FRAC_BITS:0]           i_qy,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_pixel_valid,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_last
);
    import dlr_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = C + F;
    localparam int SW = F + 2;
    localparam logic [PW:0]  HALF    = (PW + 1)'(1) << (F - 1);
    localparam logic [PW:0]  HALF_M1 = HALF - 1'b1;
    localparam logic [C-1:0] CMAX    = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] CMIN    = {1'b1, {(C-1){1'b0}}};

    t_bk_state r_state;
    t_bk_state n_state;

    logic         hd_action;
    logic [C-1:0] hd_x0;
    logic [C-1:0] hd_y0;
    logic         hd_sx;
    logic         hd_sy;

    logic [PW-1:0] r_pos_x;
    logic [PW-1:0] r_pos_y;
    logic [SW-1:0] r_step_x;
    logic [SW-1:0] r_step_y;
    logic [C:0]    r_left;
    logic          r_sx;
    logic          r_sy;

    logic          r_out_valid;
    logic          r_pix_valid;
    logic [C-1:0]  r_pix_x;
    logic [C-1:0]  r_pix_y;
    logic          r_last;

    logic          out_free;
    logic          load_line;
    logic          load_step;
    logic          emit;
    logic          active;
    logic [SW-1:0] qx_ext;
    logic [SW-1:0] qy_ext;
    logic [PW:0]   sum_x;
    logic [PW:0]   sum_y;
    logic [C:0]    rnd_x;
    logic [C:0]    rnd_y;
    logic [C-1:0]  pix_x;
    logic [C-1:0]  pix_y;

    assign hd_action = i_cmd[5*C+2];
    assign hd_x0     = i_cmd[5*C+1:4*C+2];
    assign hd_y0     = i_cmd[4*C+1:3*C+2];
    assign hd_sx     = i_cmd[3*C+1];
    assign hd_sy     = i_cmd[3*C];
    assign o_adx     = i_cmd[3*C-1:2*C];
    assign o_ady     = i_cmd[2*C-1:C];
    assign o_side    = i_cmd[C-1:0];

    assign out_free = !r_out_valid || !i_stall;
    assign active   = (r_left != '0);
    assign qx_ext   = {1'b0, i_qx};
    assign qy_ext   = {1'b0, i_qy};

    // Negative positions add one less than a half so that ties round away from zero.
    always_comb begin
        sum_x = {r_pos_x[PW-1], r_pos_x} + (r_pos_x[PW-1] ? HALF_M1 : HALF);
        sum_y = {r_pos_y[PW-1], r_pos_y} + (r_pos_y[PW-1] ? HALF_M1 : HALF);
        rnd_x = sum_x[PW:F];
        rnd_y = sum_y[PW:F];
        pix_x = (rnd_x[C] != rnd_x[C-1]) ? (rnd_x[C] ? CMIN : CMAX) : rnd_x[C-1:0];
        pix_y = (rnd_y[C] != rnd_y[C-1]) ? (rnd_y[C] ? CMIN : CMAX) : rnd_y[C-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        o_div_start = 1'b0;
        load_line   = 1'b0;
        load_step   = 1'b0;
        emit        = 1'b0;
        case (r_state)
            BK_RUN: begin
                if (!i_empty) begin
                    if (hd_action == ACT_START) begin
                        o_pop     = 1'b1;
                        load_line = 1'b1;
                        if (o_side != '0) begin
                            o_div_start = 1'b1;
                            n_state     = BK_DIV;
                        end
                    end else if (out_free) begin
                        o_pop = 1'b1;
                        emit  = 1'b1;
                    end
                end
            end
            BK_DIV: begin
                if (i_div_done) begin
                    load_step = 1'b1;
                    n_state   = BK_RUN;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_step_x <= '0;
            r_step_y <= '0;
            r_left   <= '0;
            r_sx     <= 1'b0;
            r_sy     <= 1'b0;
        end else if (load_line) begin
            r_pos_x  <= {hd_x0, {F{1'b0}}};
            r_pos_y  <= {hd_y0, {F{1'b0}}};
            r_step_x <= '0;
            r_step_y <= '0;
            r_left   <= {1'b0, o_side};
            r_sx     <= hd_sx;
            r_sy     <= hd_sy;
        end else if (load_step) begin
            r_step_x <= r_sx ? SW'(-qx_ext) : qx_ext;
            r_step_y <= r_sy ? SW'(-qy_ext) : qy_ext;
        end else if (emit && active) begin
            r_pos_x <= r_pos_x + {{(C-2){r_step_x[SW-1]}}, r_step_x};
            r_pos_y <= r_pos_y + {{(C-2){r_step_y[SW-1]}}, r_step_y};
            r_left  <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pix_valid <= active;
            r_pix_x     <= active ? pix_x : '0;
            r_pix_y     <= active ? pix_y : '0;
            r_last      <= !active || (r_left == (C+1)'(1));
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_valid = r_pix_valid;
    assign o_pixel_x     = r_pix_x;
    assign o_pixel_y     = r_pix_y;
    assign o_last        = r_last;

endmodule
`default_nettype wire

@@ hdl/dlr_chk.sv @@
// Port-level checks of the line rasterizer and their binding to the top level.
`default_nettype none
`include "dda_line_rasterizer_defines.svh"
module dlr_chk #(
    parameter int COORD_BITS = 12
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_stall,
    input wire                  o_valid,
    input wire                  i_stall,
    input wire                  o_pixel_valid,
    input wire [COORD_BITS-1:0] o_pixel_x,
    input wire [COORD_BITS-1:0] o_pixel_y,
    input wire                  o_last
);
    logic [2*COORD_BITS+1:0] out_word;
    logic                    idle_shape;

    assign out_word   = {o_pixel_valid, o_pixel_x, o_pixel_y, o_last};
    assign idle_shape = o_last && (o_pixel_x == '0) && (o_pixel_y == '0);

    `DLR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_word))
    `DLR_ASSERT_SAME(a_idle_result, i_clk, i_rst_n, o_valid && !o_pixel_valid, idle_shape)
    `DLR_ASSERT_ALWAYS_NEXT(a_reset_out, i_clk, !i_rst_n, !o_valid)
    `DLR_ASSERT_ALWAYS_NEXT(a_reset_in, i_clk, !i_rst_n, !o_stall)

endmodule

bind dda_line_rasterizer dlr_chk #(
    .COORD_BITS(COORD_BITS)
) u_dlr_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_pixel_valid(o_pixel_valid),
    .o_pixel_x    (o_pixel_x),
    .o_pixel_y    (o_pixel_y),
    .o_last       (o_last)
);
`default_nettype wire

@@ bench/dda_line_rasterizer_test.sv @@
// Self-checking DDA line rasterizer bench: directed rows, an output hold, random lines.
module dda_line_rasterizer_test;
    import dlr_pkg::*;

    localparam int CW = 12;
    localparam int FW = 16;
    localparam longint ONE = longint'(1) << FW;
    localparam longint HALF = ONE / 2;
    localparam longint MAX_C = (longint'(1) << (CW - 1)) - 1;
    localparam longint MIN_C = -MAX_C - 1;
    localparam int HOLD_CYCLES = 150;
    localparam int ITEM_GOAL = 900;
    localparam int DRAIN_CYCLES = FW + 8;
    localparam int PLAN_ROWS = 25;

    typedef struct packed {
        logic                 pixel_valid;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } t_pixel;

    typedef struct packed {
        logic                 act;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        bit                   fixed_exp;
        t_pixel               want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_action;
    logic signed [CW-1:0] i_start_x;
    logic signed [CW-1:0] i_start_y;
    logic signed [CW-1:0] i_end_x;
    logic signed [CW-1:0] i_end_y;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_pixel_valid;
    logic signed [CW-1:0] o_pixel_x;
    logic signed [CW-1:0] o_pixel_y;
    logic                 o_last;

    longint pos_x;
    longint pos_y;
    longint slope_x;
    longint slope_y;
    int     pixels_left;
    t_pixel expected_pixels[$];
    bit     hold_req;
    bit     hold_over;
    int     errors;
    int     items_sent;
    int     lines_started;
    int     pixels_checked;
    int     idle_checked;
    t_stim_row plan[PLAN_ROWS];

    dda_line_rasterizer #(
        .COORD_BITS(CW),
        .FRAC_BITS(FW)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_action(i_action),
        .i_start_x(i_start_x),
        .i_start_y(i_start_y),
        .i_end_x(i_end_x),
        .i_end_y(i_end_y),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_pixel_valid(o_pixel_valid),
        .o_pixel_x(o_pixel_x),
        .o_pixel_y(o_pixel_y),
        .o_last(o_last)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic signed [CW-1:0] rand_coord();
        return CW'($urandom);
    endfunction

    function automatic longint fixed_slope(longint delta, longint side);
        longint q;
        if (side == 0) begin
            return 0;
        end
        q = (((delta < 0) ? -delta : delta) * ONE + side / 2) / side;
        return (delta < 0) ? -q : q;
    endfunction

    function automatic logic signed [CW-1:0] round_to_grid(longint p);
        longint r;
        if (p >= 0) begin
            r = (p + HALF) >>> FW;
        end else begin
            r = -((-p + HALF) >>> FW);
        end
        if (r > MAX_C) begin
            r = MAX_C;
        end
        if (r < MIN_C) begin
            r = MIN_C;
        end
        return r[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] pick_end(int s, int d);
        int e;
        e = s + d;
        if (e > MAX_C || e < MIN_C) begin
            e = s - d;
        end
        return e[CW-1:0];
    endfunction

    function automatic t_stim_row plan_row(logic act, int sx, int sy, int ex, int ey,
                                           int fixed_exp, logic pv, int px, int py,
                                           logic lst);
        t_stim_row r;
        r.act = act;
        r.sx = CW'(sx);
        r.sy = CW'(sy);
        r.ex = CW'(ex);
        r.ey = CW'(ey);
        r.fixed_exp = (fixed_exp != 0);
        r.want.pixel_valid = pv;
        r.want.x = CW'(px);
        r.want.y = CW'(py);
        r.want.last = lst;
        return r;
    endfunction

    task automatic advance_raster(input logic act,
                                  input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                                  input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey,
                                  output bit emits, output t_pixel px);
        longint dx;
        longint dy;
        longint side;
        emits = 1'b1;
        px = '0;
        if (act == ACT_START) begin
            dx = longint'(ex);
            dx = dx - longint'(sx);
            dy = longint'(ey);
            dy = dy - longint'(sy);
            side = (dx < 0) ? -dx : dx;
            if (((dy < 0) ? -dy : dy) > side) begin
                side = (dy < 0) ? -dy : dy;
            end
            slope_x = fixed_slope(dx, side);
            slope_y = fixed_slope(dy, side);
            pos_x = longint'(sx);
            pos_x = pos_x * ONE;
            pos_y = longint'(sy);
            pos_y = pos_y * ONE;
            pixels_left = int'(side);
            emits = 1'b0;
            lines_started++;
        end else if (pixels_left == 0) begin
            px.last = 1'b1;
        end else begin
            px.pixel_valid = 1'b1;
            px.x = round_to_grid(pos_x);
            px.y = round_to_grid(pos_y);
            px.last = (pixels_left == 1);
            pos_x += slope_x;
            pos_y += slope_y;
            pixels_left--;
        end
    endtask

    task automatic send_item(input logic act,
                             input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                             input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey,
                             input bit fixed_exp, input t_pixel fixed_px);
        bit     emits;
        t_pixel px;
        int     k;
        int     n;
        i_valid <= 1'b1;
        i_action <= act;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x <= ex;
        i_end_y <= ey;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        advance_raster(act, sx, sy, ex, ey, emits, px);
        if (emits) begin
            expected_pixels.push_back(fixed_exp ? fixed_px : px);
        end
        items_sent++;
        if (!hold_req || hold_over) begin
            k = $urandom_range(0, 9);
            n = (k < 6) ? 0 : (k < 9) ? $urandom_range(1, 3) : $urandom_range(10, 30);
            if (n > 0) begin
                i_valid <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    endtask

    task automatic check_field(input string name, input logic signed [CW-1:0] want,
                               input logic signed [CW-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel transfer with nothing expected, got x=%0d y=%0d",
                         $time, o_pixel_x, o_pixel_y);
            end else begin
                want = expected_pixels.pop_front();
                check_field("pixel_valid", CW'(want.pixel_valid), CW'(o_pixel_valid));
                check_field("pixel_x", want.x, o_pixel_x);
                check_field("pixel_y", want.y, o_pixel_y);
                check_field("last", CW'(want.last), CW'(o_last));
                if (want.pixel_valid) begin
                    pixels_checked++;
                end else begin
                    idle_checked++;
                end
            end
        end
    end

    initial begin : output_side
        int  k;
        int  n;
        bit  s;
        i_stall = 1'b0;
        hold_over = 1'b0;
        forever begin
            if (hold_req && !hold_over) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_over = 1'b1;
            end else begin
                k = $urandom_range(0, 9);
                if (k < 5) begin
                    s = 1'b0;
                    n = $urandom_range(1, 20);
                end else if (k < 9) begin
                    s = 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    s = 1'b1;
                    n = $urandom_range(10, 40);
                end
                i_stall <= s;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : input_side
        int                   k;
        int                   n;
        int                   span;
        int                   dx;
        int                   dy;
        int                   side;
        int                   steps;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] d;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_START;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x = '0;
        i_end_y = '0;
        hold_req = 1'b0;
        items_sent = 0;
        lines_started = 0;
        pos_x = 0;
        pos_y = 0;
        slope_x = 0;
        slope_y = 0;
        pixels_left = 0;

        plan[0]  = plan_row(ACT_STEP, 0, 0, 0, 0, 1, 1'b0, 0, 0, 1'b1);
        plan[1]  = plan_row(ACT_START, -2048, -2048, 2047, 2047, 0, 1'b0, 0, 0, 1'b0);
        plan[2]  = plan_row(ACT_STEP, 0, 0, 0, 0, 1, 1'b1, -2048, -2048, 1'b0);
        plan[3]  = plan_row(ACT_STEP, -1, -1, -1, -1, 0, 1'b0, 0, 0, 1'b0);
        plan[4]  = plan_row(ACT_START, 2047, 2047, -2048, -2048, 0, 1'b0, 0, 0, 1'b0);
        plan[5]  = plan_row(ACT_STEP, 0, 0, 0, 0, 1, 1'b1, 2047, 2047, 1'b0);
        plan[6]  = plan_row(ACT_START, 5, -5, 5, -5, 0, 1'b0, 0, 0, 1'b0);
        plan[7]  = plan_row(ACT_STEP, 0, 0, 0, 0, 1, 1'b0, 0, 0, 1'b1);
        plan[8]  = plan_row(ACT_START, 0, 0, 1, 0, 0, 1'b0, 0, 0, 1'b0);
        plan[9]  = plan_row(ACT_STEP, 0, 0, 0, 0, 1, 1'b1, 0, 0, 1'b1);
        plan[10] = plan_row(ACT_STEP, 0, 0, 0, 0, 1, 1'b0, 0, 0, 1'b1);
        plan[11] = plan_row(ACT_START, 0, 0, 2, 1, 0, 1'b0, 0, 0, 1'b0);
        plan[12] = plan_row(ACT_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        plan[13] = plan_row(ACT_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        plan[14] = plan_row(ACT_START, 0, 0, -2, -1, 0, 1'b0, 0, 0, 1'b0);
        plan[15] = plan_row(ACT_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        plan[16] = plan_row(ACT_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        plan[17] = plan_row(ACT_START, -3, 2, 0, -7, 0, 1'b0, 0, 0, 1'b0);
        plan[18] = plan_row(ACT_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        plan[19] = plan_row(ACT_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        plan[20] = plan_row(ACT_START, 100, -100, -100, 100, 0, 1'b0, 0, 0, 1'b0);
        plan[21] = plan_row(ACT_STEP, 0, 0, 0, 0, 1, 1'b1, 100, -100, 1'b0);
        plan[22] = plan_row(ACT_START, 7, 7, 7, 10, 0, 1'b0, 0, 0, 1'b0);
        plan[23] = plan_row(ACT_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);
        plan[24] = plan_row(ACT_STEP, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            send_item(plan[i].act, plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey,
                      plan[i].fixed_exp, plan[i].want);
        end

        // The output side holds off while a long line keeps the input busy.
        hold_req = 1'b1;
        send_item(ACT_START, -100, 50, 100, -30, 0, '0);
        repeat (40) send_item(ACT_STEP, rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), 0, '0);

        while (items_sent < ITEM_GOAL) begin
            k = $urandom_range(0, 19);
            if (k < 14) begin
                a = rand_coord();
                b = rand_coord();
                span = ($urandom_range(0, 3) == 0) ? 60 : 12;
                c = pick_end(int'(a), $urandom_range(0, 2 * span) - span);
                d = pick_end(int'(b), $urandom_range(0, 2 * span) - span);
                if ($urandom_range(0, 15) == 0) begin
                    c = a;
                    d = b;
                end
                dx = int'(c) - int'(a);
                dy = int'(d) - int'(b);
                dx = (dx < 0) ? -dx : dx;
                dy = (dy < 0) ? -dy : dy;
                side = (dx > dy) ? dx : dy;
                steps = side + $urandom_range(0, 2);
                if ($urandom_range(0, 4) == 0) begin
                    steps = $urandom_range(0, side);
                end
                send_item(ACT_START, a, b, c, d, 0, '0);
                repeat (steps) send_item(ACT_STEP, rand_coord(), rand_coord(), rand_coord(),
                                         rand_coord(), 0, '0);
            end else if (k < 17) begin
                send_item(ACT_START, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          0, '0);
                n = $urandom_range(1, 8);
                repeat (n) send_item(ACT_STEP, rand_coord(), rand_coord(), rand_coord(),
                                     rand_coord(), 0, '0);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                                     rand_coord(), rand_coord(), 0, '0);
            end
        end
        i_valid <= 1'b0;

        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items over %0d lines; checked %0d pixels and %0d idle replies.",
                 items_sent, lines_started, pixels_checked, idle_checked);
        $display("The output was held off for %0d cycles once with the input still busy.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
